// ----- design/sbcc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbcc_pkg: shared types and constants
// Widths, table depth and face decode for the segment/box collision check.
// ----------------------------------------------------------------------------
package sbcc_pkg;
  localparam int MaxBoxes   = 64;
  localparam int CoordWidth = 32;
  localparam int SlotWidth  = $clog2(MaxBoxes);
  localparam int CountWidth = 7;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic [SlotWidth-1:0]         slot_t;
  typedef logic [CountWidth-1:0]        count_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Face order: z low, y low, x high, y high, x low, z high.
  function automatic logic [1:0] face_axis(input logic [2:0] f);
    case (f)
      3'd0: face_axis = 2'd2;
      3'd1: face_axis = 2'd1;
      3'd2: face_axis = 2'd0;
      3'd3: face_axis = 2'd1;
      3'd4: face_axis = 2'd0;
      default: face_axis = 2'd2;
    endcase
  endfunction

  function automatic logic face_high(input logic [2:0] f);
    face_high = (f == 3'd2) || (f == 3'd3) || (f == 3'd5);
  endfunction

  function automatic logic [1:0] next_axis(input logic [1:0] a);
    next_axis = (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction
endpackage

// ----- design/sbcc_mul.sv -----
// ----------------------------------------------------------------------------
// sbcc_mul: shared signed multiplier
// One registered 33x33 signed product, used by every bound test in turn.
// ----------------------------------------------------------------------------
module sbcc_mul (
  input  logic          clk,
  input  sbcc_pkg::diff_t a,
  input  sbcc_pkg::diff_t b,
  output sbcc_pkg::prod_t p
);
  import sbcc_pkg::*;

  always_ff @(posedge clk) begin
    p <= prod_t'(a) * prod_t'(b);
  end
endmodule

// ----- design/segment_box_collision_check.sv -----
// ----------------------------------------------------------------------------
// segment_box_collision_check: segment versus obstacle box table
// Box writes fill a 64-entry table; a query checks a segment against the
// first obstacle_count boxes, at most 64, and answers path_clear.
// ----------------------------------------------------------------------------
// After a box write is accepted, in_ready drops and comes back from idle. After
// its accept, a query spends a read state on each box it checks, for the table
// read, and a box state for the endpoint test. Each of the six faces then has
// a face state, plus MUL_A, WAIT_A, MUL_B, WAIT_B and CMP for each bound test
// that the face runs. A face runs up to four bound tests one after the other
// through one shared 33x33 multiplier, with two products for each test. The
// walk ends early at the first hit. The done state then loads the result. The
// result waits in an output register while the next item is accepted.
module segment_box_collision_check (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     obstacle_count_we,
  input  sbcc_pkg::count_t         obstacle_count_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     command,
  input  sbcc_pkg::slot_t          box_slot,
  input  sbcc_pkg::coord_t         first_x,
  input  sbcc_pkg::coord_t         first_y,
  input  sbcc_pkg::coord_t         first_z,
  input  sbcc_pkg::coord_t         second_x,
  input  sbcc_pkg::coord_t         second_y,
  input  sbcc_pkg::coord_t         second_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     path_clear
);
  import sbcc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_BOX, ST_FACE, ST_MUL_A, ST_MUL_B, ST_WAIT_A,
    ST_WAIT_B, ST_CMP, ST_DONE
  } state_t;

  state_t state;
  count_t obstacle_count;
  count_t count_lim;
  logic [CountWidth:0] box_idx;
  logic [2:0] face;
  logic [1:0] test;  // bit1: second axis, bit0: upper bound
  logic       clear;

  coord_t s [3];
  coord_t d [3];
  coord_t lo [3];
  coord_t hi [3];
  coord_t mem_lo [3][MaxBoxes];
  coord_t mem_hi [3][MaxBoxes];
  coord_t rd_lo [3];
  coord_t rd_hi [3];
  diff_t  u, den;
  prod_t  num;
  diff_t  ma, mb;
  prod_t  mp;

  sbcc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && command == CMD_WRITE) begin
      mem_lo[0][box_slot] <= first_x;  mem_hi[0][box_slot] <= second_x;
      mem_lo[1][box_slot] <= first_y;  mem_hi[1][box_slot] <= second_y;
      mem_lo[2][box_slot] <= first_z;  mem_hi[2][box_slot] <= second_z;
    end
    for (int k = 0; k < 3; k++) begin
      rd_lo[k] <= mem_lo[k][box_idx[SlotWidth-1:0]];
      rd_hi[k] <= mem_hi[k][box_idx[SlotWidth-1:0]];
    end
  end

  // Face decode.
  logic [1:0] ax, b1, b2, bsel;
  coord_t     c, smin_a, smax_a, smin_b, smax_b, lbound, ubound, bnd;
  logic       face_skip, in_s, in_d;
  diff_t      e_a;
  always_comb begin
    ax   = face_axis(face);
    b1   = next_axis(ax);
    b2   = next_axis(b1);
    bsel = test[1] ? b2 : b1;
    c    = face_high(face) ? hi[ax] : lo[ax];
    e_a  = diff_t'(s[ax]) - diff_t'(d[ax]);
    smin_a = (s[ax] < d[ax]) ? s[ax] : d[ax];
    smax_a = (s[ax] < d[ax]) ? d[ax] : s[ax];
    smin_b = (s[bsel] < d[bsel]) ? s[bsel] : d[bsel];
    smax_b = (s[bsel] < d[bsel]) ? d[bsel] : s[bsel];
    lbound = (lo[bsel] > smin_b) ? lo[bsel] : smin_b;
    ubound = (hi[bsel] < smax_b) ? hi[bsel] : smax_b;
    bnd    = test[0] ? ubound : lbound;
    face_skip = (e_a == '0) || (lo[b1] == hi[b1]) || (lo[b2] == hi[b2]) ||
                (c < lo[ax]) || (c > hi[ax]) || (c < smin_a) || (c > smax_a);
    in_s = 1'b1;
    in_d = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (s[k] < rd_lo[k] || s[k] > rd_hi[k]) in_s = 1'b0;
      if (d[k] < rd_lo[k] || d[k] > rd_hi[k]) in_d = 1'b0;
    end
    // First product u*e_b, second (bound - S_b)*den.
    if (state == ST_MUL_A) begin
      ma = u;
      mb = diff_t'(s[bsel]) - diff_t'(d[bsel]);
    end else begin
      ma = diff_t'(bnd) - diff_t'(s[bsel]);
      mb = den;
    end
  end

  logic fail;
  assign fail = test[0] ? (num > mp) : (num < mp);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      in_ready <= 1'b0;
      out_valid <= 1'b0;
      obstacle_count <= '0;
    end else begin
      if (obstacle_count_we) obstacle_count <= obstacle_count_wdata;
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            if (command == CMD_QUERY) begin
              s[0] <= first_x;  s[1] <= first_y;  s[2] <= first_z;
              d[0] <= second_x; d[1] <= second_y; d[2] <= second_z;
              count_lim <= (obstacle_count > count_t'(MaxBoxes)) ?
                           count_t'(MaxBoxes) : obstacle_count;
              box_idx <= '0;
              clear <= 1'b1;
              state <= ST_READ;
            end
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_READ: begin
          if (box_idx >= {1'b0, count_lim}) state <= ST_DONE;
          else state <= ST_BOX;
        end
        ST_BOX: begin
          lo <= rd_lo;
          hi <= rd_hi;
          face <= '0;
          if (in_s || in_d) begin
            clear <= 1'b0;
            state <= ST_DONE;
          end else begin
            state <= ST_FACE;
          end
        end
        ST_FACE: begin
          test <= '0;
          u   <= (e_a < 0) ? diff_t'(s[ax]) - diff_t'(c) : diff_t'(c) - diff_t'(s[ax]);
          den <= (e_a < 0) ? -e_a : e_a;
          if (face_skip) begin
            if (face == 3'd5) begin
              box_idx <= box_idx + 1'b1;
              state <= ST_READ;
            end else begin
              face <= face + 3'd1;
            end
          end else begin
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A: state <= ST_WAIT_A;
        ST_WAIT_A: begin
          num <= mp;
          state <= ST_MUL_B;
        end
        ST_MUL_B: state <= ST_WAIT_B;
        ST_WAIT_B: state <= ST_CMP;
        ST_CMP: begin
          if (fail) begin
            if (face == 3'd5) begin
              box_idx <= box_idx + 1'b1;
              state <= ST_READ;
            end else begin
              face <= face + 3'd1;
              state <= ST_FACE;
            end
          end else if (test == 2'd3) begin
            clear <= 1'b0;
            state <= ST_DONE;
          end else begin
            test <= test + 2'd1;
            state <= ST_MUL_A;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            path_clear <= clear;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The wait state keeps the product in place for the compare.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_BOX) |-> box_idx < {1'b0, count_lim})
    else $error("box index beyond count");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CMD_QUERY) |=> !in_ready)
    else $error("query accepted twice");
endmodule

// ----- verif/sbcc_checker.sv -----
// ----------------------------------------------------------------------------
// sbcc_checker: result predictor and comparator
// Watches both channels of the collision check, keeps its own copy of the box
// table and the obstacle count, and compares every answer with the prediction.
// ----------------------------------------------------------------------------
module sbcc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               obstacle_count_we,
  input  sbcc_pkg::count_t   obstacle_count_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               command,
  input  sbcc_pkg::slot_t    box_slot,
  input  sbcc_pkg::coord_t   first_x,
  input  sbcc_pkg::coord_t   first_y,
  input  sbcc_pkg::coord_t   first_z,
  input  sbcc_pkg::coord_t   second_x,
  input  sbcc_pkg::coord_t   second_y,
  input  sbcc_pkg::coord_t   second_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               path_clear,
  output int                 fail_count,
  output int                 pending
);
  import sbcc_pkg::*;

  typedef logic signed [63:0]  wide_t;
  typedef logic signed [127:0] prod128_t;

  wide_t  tbl_lo [MaxBoxes][3];
  wide_t  tbl_hi [MaxBoxes][3];
  count_t boxes_checked;
  logic   clear_queue [$];

  function automatic int face_dim(input int f);
    case (f)
      0: return 2;
      1: return 1;
      2: return 0;
      3: return 1;
      4: return 0;
      default: return 2;
    endcase
  endfunction

  function automatic bit face_uses_high(input int f);
    return (f == 2) || (f == 3) || (f == 5);
  endfunction

  function automatic bit point_in_box(input int j, input wide_t p [3]);
    for (int k = 0; k < 3; k++)
      if (p[k] < tbl_lo[j][k] || p[k] > tbl_hi[j][k]) return 0;
    return 1;
  endfunction

  // Exact test of whether the segment crosses face f of box j within the box and the segment.
  function automatic bit crosses_face(input int j, input int f, input wide_t s [3],
                                      input wide_t e [3], input wide_t smin [3],
                                      input wide_t smax [3]);
    int ax, b;
    wide_t c, u, den, lb, ub;
    prod128_t num;
    ax = face_dim(f);
    c = face_uses_high(f) ? tbl_hi[j][ax] : tbl_lo[j][ax];
    if (e[ax] == 0) return 0;
    for (int n = 1; n < 3; n++) begin
      b = (ax + n) % 3;
      if (tbl_lo[j][b] == tbl_hi[j][b]) return 0;
    end
    if (c < tbl_lo[j][ax] || c > tbl_hi[j][ax] || c < smin[ax] || c > smax[ax])
      return 0;
    u = c - s[ax];
    den = e[ax];
    if (den < 0) begin
      u = -u;
      den = -den;
    end
    for (int n = 1; n < 3; n++) begin
      b = (ax + n) % 3;
      lb = (tbl_lo[j][b] > smin[b]) ? tbl_lo[j][b] : smin[b];
      ub = (tbl_hi[j][b] < smax[b]) ? tbl_hi[j][b] : smax[b];
      num = prod128_t'(u) * prod128_t'(e[b]);
      if (num < prod128_t'(lb - s[b]) * prod128_t'(den)) return 0;
      if (num > prod128_t'(ub - s[b]) * prod128_t'(den)) return 0;
    end
    return 1;
  endfunction

  function automatic bit predict_clear(input wide_t s [3], input wide_t d [3]);
    wide_t e [3], smin [3], smax [3];
    int limit;
    for (int k = 0; k < 3; k++) begin
      e[k] = s[k] - d[k];
      smin[k] = (s[k] < d[k]) ? s[k] : d[k];
      smax[k] = (s[k] < d[k]) ? d[k] : s[k];
    end
    limit = (boxes_checked > MaxBoxes) ? MaxBoxes : int'(boxes_checked);
    for (int j = 0; j < limit; j++) begin
      if (point_in_box(j, s) || point_in_box(j, d)) return 0;
      for (int f = 0; f < 6; f++)
        if (crosses_face(j, f, s, e, smin, smax)) return 0;
    end
    return 1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending = clear_queue.size();

  always @(posedge clk) begin
    wide_t a [3], b [3];
    logic expected;
    if (rst) begin
      boxes_checked <= '0;
      fail_count = 0;
    end else begin
      if (obstacle_count_we) boxes_checked <= obstacle_count_wdata;
      if (in_valid && in_ready) begin
        a[0] = first_x;  a[1] = first_y;  a[2] = first_z;
        b[0] = second_x; b[1] = second_y; b[2] = second_z;
        if (command == CMD_WRITE) begin
          tbl_lo[box_slot] = a;
          tbl_hi[box_slot] = b;
        end else begin
          clear_queue = {clear_queue, predict_clear(a, b)};
        end
      end
      if (out_valid && out_ready) begin
        if (clear_queue.size() == 0) begin
          report_mismatch("answer with no query outstanding");
        end else begin
          expected = clear_queue.pop_front();
          if (path_clear !== expected)
            report_mismatch($sformatf("path_clear %b, expected %b", path_clear, expected));
        end
      end
    end
  end
endmodule

// ----- verif/tb_segment_box_collision_check.sv -----
// ----------------------------------------------------------------------------
// tb_segment_box_collision_check: testbench top
// Loads obstacle tables and sends segment queries, directed then random, with
// random stalls on both channels and several obstacle counts.
// ----------------------------------------------------------------------------
module tb_segment_box_collision_check;
  import sbcc_pkg::*;

  localparam int WatchdogLimit = 200000;
  localparam int Unit = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic obstacle_count_we = 1'b0;
  count_t obstacle_count_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_WRITE;
  slot_t box_slot = '0;
  coord_t first_x = '0, first_y = '0, first_z = '0;
  coord_t second_x = '0, second_y = '0, second_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic path_clear;
  int fail_count, pending;
  int idle_cycles = 0;
  bit calm = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_box_collision_check dut (.*);
  sbcc_checker chk (.*);

  // Receiver: random stall bursts until the final stretch.
  always @(posedge clk) begin
    int burst;
    if (rst) begin
      out_ready <= 1'b0;
      burst = 0;
    end else if (burst > 0) begin
      burst--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The valid stays high after an accept until the next item or an idle gap replaces it.
  task automatic send(input logic cmd, input slot_t slot, input coord_t ax, input coord_t ay,
                      input coord_t az, input coord_t bx, input coord_t by, input coord_t bz);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    command <= cmd;
    box_slot <= slot;
    first_x <= ax; first_y <= ay; first_z <= az;
    second_x <= bx; second_y <= by; second_z <= bz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_box(input slot_t slot, input coord_t ax, input coord_t ay,
                           input coord_t az, input coord_t bx, input coord_t by,
                           input coord_t bz);
    send(CMD_WRITE, slot, ax, ay, az, bx, by, bz);
  endtask

  // Settle the block, then set the count; only slots already written may be checked.
  task automatic set_count(input int n);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    obstacle_count_we <= 1'b1;
    obstacle_count_wdata <= count_t'(n);
    @(posedge clk);
    obstacle_count_we <= 1'b0;
  endtask

  function automatic coord_t small_coord();
    return coord_t'($signed($urandom_range(0, 40 * Unit)) - 20 * Unit);
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(32'h8000_0000);
      1: return coord_t'(32'h7fff_ffff);
      2: return coord_t'($urandom);
      default: return small_coord();
    endcase
  endfunction

  task automatic random_box(input slot_t slot);
    coord_t l [3], h [3], t;
    for (int k = 0; k < 3; k++) begin
      l[k] = small_coord();
      h[k] = l[k] + coord_t'($urandom_range(0, 8 * Unit));
      if ($urandom_range(0, 15) == 0) h[k] = l[k];
      if ($urandom_range(0, 15) == 0) begin
        t = l[k]; l[k] = h[k]; h[k] = t;
      end
      if ($urandom_range(0, 30) == 0) l[k] = any_coord();
    end
    write_box(slot, l[0], l[1], l[2], h[0], h[1], h[2]);
  endtask

  task automatic random_query();
    coord_t p [6];
    for (int k = 0; k < 6; k++)
      p[k] = ($urandom_range(0, 9) == 0) ? any_coord() : small_coord();
    if ($urandom_range(0, 7) == 0) p[3 + $urandom_range(0, 2)] = p[0];
    if ($urandom_range(0, 15) == 0) begin
      p[3] = p[0]; p[4] = p[1]; p[5] = p[2];
    end
    send(CMD_QUERY, slot_t'($urandom), p[0], p[1], p[2], p[3], p[4], p[5]);
  endtask

  initial begin
    int counts [6] = '{1, 8, 64, 3, 127, 32};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: count zero, then boxes with edge values and special shapes.
    send(CMD_QUERY, '1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    write_box(slot_t'(0), 0, 0, 0, Unit, Unit, Unit);
    write_box(slot_t'(1), 4 * Unit, 0, 0, 4 * Unit, Unit, Unit);
    write_box(slot_t'(2), 8 * Unit, Unit, 0, 7 * Unit, 0, Unit);
    write_box(slot_t'(63), 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    for (int j = 3; j < MaxBoxes - 1; j++)
      write_box(slot_t'(j), 32'sh7fff_0000, 32'sh7fff_0000, 32'sh7fff_0000,
                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    set_count(64);
    send(CMD_QUERY, slot_t'(0), Unit / 2, Unit / 2, Unit / 2, Unit / 2, Unit / 2, Unit / 2);
    send(CMD_QUERY, slot_t'(0), -Unit, Unit / 2, Unit / 2, 2 * Unit, Unit / 2, Unit / 2);
    send(CMD_QUERY, slot_t'(0), 2 * Unit, Unit / 2, Unit / 2, 6 * Unit, Unit / 2, Unit / 2);
    send(CMD_QUERY, slot_t'(0), 3 * Unit, -Unit, -Unit, 3 * Unit, 2 * Unit, 2 * Unit);
    send(CMD_QUERY, slot_t'(0), 6 * Unit, Unit / 2, Unit / 2, 9 * Unit, Unit / 2, Unit / 2);
    send(CMD_QUERY, slot_t'(0), -Unit, -Unit, 2 * Unit, 2 * Unit, 2 * Unit, -Unit);
    send(CMD_QUERY, slot_t'(0), 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send(CMD_QUERY, slot_t'(0), 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
         32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send(CMD_QUERY, slot_t'(0), Unit, Unit, Unit, 2 * Unit, 2 * Unit, 2 * Unit);

    // Random phases with different counts; all slots are written already.
    foreach (counts[i]) begin
      set_count(counts[i]);
      for (int n = 0; n < 183; n++) begin
        if (i == 5 && n > 150) calm = 1;
        if ($urandom_range(0, 3) == 0) random_box(slot_t'($urandom));
        else random_query();
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
design/sbcc_pkg.sv
design/sbcc_mul.sv
design/segment_box_collision_check.sv
verif/sbcc_checker.sv
verif/tb_segment_box_collision_check.sv
